>>> rtl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; every other file imports this package.
package sfs_pkg;

  localparam int FRAME_BITS_DEF = 8;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int ACC_W          = 17;
  localparam int PERIOD_W       = 16;
  localparam int ELAPSED_W      = 16;
  localparam int STEP_W         = 4;
  localparam int RANGE_W        = 8;
  localparam int COLS_W         = 8;
  localparam int CELL_W         = 10;
  localparam int PLAY_W         = 2;
  localparam int INDEX_W        = 8;
  localparam int XY_W           = 18;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_FRAME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE     = 3'd7;

  // Reset values of the registers
  localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD  = 16'd16667;
  localparam logic [STEP_W-1:0]   RST_STEP_SIZE     = 4'd1;
  localparam logic [RANGE_W-1:0]  RST_FIRST_FRAME   = 8'd0;
  localparam logic [RANGE_W-1:0]  RST_LAST_FRAME    = 8'd0;
  localparam logic [COLS_W-1:0]   RST_SHEET_COLUMNS = 8'd1;
  localparam logic [CELL_W-1:0]   RST_CELL_WIDTH    = 10'd0;
  localparam logic [CELL_W-1:0]   RST_CELL_HEIGHT   = 10'd0;

  // Play modes; the reserved code plays forward
  localparam logic [PLAY_W-1:0] PLAY_FORWARD  = 2'd0;
  localparam logic [PLAY_W-1:0] PLAY_REVERSE  = 2'd1;
  localparam logic [PLAY_W-1:0] PLAY_PINGPONG = 2'd2;
  localparam logic [PLAY_W-1:0] RST_PLAY_MODE = PLAY_FORWARD;

  // Item kinds
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  typedef struct packed {
    logic [PERIOD_W-1:0] frame_period;
    logic [STEP_W-1:0]   step_size;
    logic [RANGE_W-1:0]  first_frame;
    logic [RANGE_W-1:0]  last_frame;
    logic [COLS_W-1:0]   sheet_columns;
    logic [CELL_W-1:0]   cell_width;
    logic [CELL_W-1:0]   cell_height;
    logic [PLAY_W-1:0]   play_mode;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take the item, update the animation state, seed the divider
    logic div_step;  // one restoring divide step
    logic emit;      // scale row and column, load the output register
  } cmd_t;

endpackage

>>> rtl/sfs_ifs.sv
// Handshake channels of the sprite frame sequencer: tick items in, frame results out.
// Depends on sfs_pkg for field widths.
interface sfs_tick_if import sfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, mode, elapsed, input ready);
  modport sink   (input valid, mode, elapsed, output ready);
endinterface

interface sfs_frame_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] frame_index;
  logic [XY_W-1:0]    src_x;
  logic [XY_W-1:0]    src_y;
  logic               advanced;
  logic               cycle_done;

  modport source (output valid, frame_index, src_x, src_y, advanced, cycle_done,
                  input ready);
  modport sink   (input valid, frame_index, src_x, src_y, advanced, cycle_done,
                  output ready);
endinterface

>>> rtl/sfs_ctrl.sv
// Sequencer for the sprite frame sequencer: accept, divide, emit.
// Depends on sfs_pkg; drives sfs_dpath through cmd_t.
module sfs_ctrl import sfs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;
  logic             div_last;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign div_last = (cnt == CNT_LAST);

  assign cmd.accept   = in_valid && in_ready;
  assign cmd.div_step = (state == ST_DIV);
  assign cmd.emit     = (state == ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DIV;
      ST_DIV:  if (div_last) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        cnt <= '0;
      end else if (cmd.div_step && !div_last) begin
        cnt <= cnt + 1'b1;
      end
      // hold the result until its transfer
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_DIV) && (cnt == '0))
    else $error("divide did not start after accept");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && div_last |=> (state == ST_EMIT))
    else $error("divide ran past its step count");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

>>> rtl/sfs_dpath.sv
// Datapath of the sprite frame sequencer: animation state, restoring divider,
// cell scaling and the output register. Depends on sfs_pkg; driven by sfs_ctrl.
module sfs_dpath import sfs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  input  logic                 mode,
  input  logic [ELAPSED_W-1:0] elapsed,
  output logic [INDEX_W-1:0]   frame_index,
  output logic [XY_W-1:0]      src_x,
  output logic [XY_W-1:0]      src_y,
  output logic                 advanced,
  output logic                 cycle_done
);

  localparam int SUM_W = FRAME_BITS + STEP_W + 1;

  // animation state
  logic [ACC_W-1:0]      time_accumulator, acc_next;
  logic [FRAME_BITS-1:0] current_frame, frame_next;
  logic                  moving_forward, forward_next;
  logic [FRAME_BITS-1:0] working_start, start_next;
  logic [FRAME_BITS-1:0] working_limit, limit_next;
  logic                  adv_q, done_q, done_next;

  // divider
  logic [COLS_W-1:0]     rem;
  logic [FRAME_BITS-1:0] quo;
  logic [COLS_W:0]       trial;
  logic                  trial_ge;
  logic [COLS_W-1:0]     cols;

  // tick arithmetic
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sat;
  logic             fire;
  logic [SUM_W-1:0] cur_w, step_w, lim_w, up_sum, down_floor;
  logic             go_up, pingpong, overrun;

  assign acc_sum  = {1'b0, time_accumulator} + (ACC_W + 1)'(elapsed);
  assign acc_sat  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
  assign fire     = acc_sat > ACC_W'(cfg.frame_period);

  assign cur_w      = SUM_W'(current_frame);
  assign step_w     = SUM_W'(cfg.step_size);
  assign lim_w      = SUM_W'(working_limit);
  assign up_sum     = cur_w + step_w;
  assign down_floor = lim_w + step_w;

  assign pingpong = (cfg.play_mode == PLAY_PINGPONG);
  assign go_up    = pingpong ? moving_forward : (cfg.play_mode != PLAY_REVERSE);
  // stepping down: index - step < limit is index < limit + step
  assign overrun  = go_up ? (up_sum > lim_w) : (cur_w < down_floor);

  always_comb begin
    acc_next     = time_accumulator;
    frame_next   = current_frame;
    forward_next = moving_forward;
    start_next   = working_start;
    limit_next   = working_limit;
    done_next    = 1'b0;
    if (mode == MODE_RESTART) begin
      acc_next     = '0;
      forward_next = 1'b1;
      start_next   = FRAME_BITS'(cfg.first_frame);
      limit_next   = FRAME_BITS'(cfg.last_frame);
      frame_next   = FRAME_BITS'(cfg.first_frame);
    end else begin
      acc_next = acc_sat;
      if (fire) begin
        acc_next = acc_sat - ACC_W'(cfg.frame_period);
        if (overrun && pingpong) begin
          // turn around: clamp to the bound and swap the range
          frame_next   = working_limit;
          start_next   = working_limit;
          limit_next   = working_start;
          forward_next = !moving_forward;
        end else if (overrun) begin
          frame_next = working_start;
          done_next  = 1'b1;
        end else if (go_up) begin
          frame_next = up_sum[FRAME_BITS-1:0];
        end else begin
          frame_next = current_frame - FRAME_BITS'(cfg.step_size);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_accumulator <= '0;
      current_frame    <= FRAME_BITS'(RST_FIRST_FRAME);
      moving_forward   <= 1'b1;
      working_start    <= FRAME_BITS'(RST_FIRST_FRAME);
      working_limit    <= FRAME_BITS'(RST_LAST_FRAME);
    end else if (cmd.accept) begin
      time_accumulator <= acc_next;
      current_frame    <= frame_next;
      moving_forward   <= forward_next;
      working_start    <= start_next;
      working_limit    <= limit_next;
    end
  end

  // zero columns count as one
  assign cols     = (cfg.sheet_columns == '0) ? COLS_W'(1) : cfg.sheet_columns;
  assign trial    = {rem, quo[FRAME_BITS-1]};
  assign trial_ge = trial >= {1'b0, cols};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem   <= '0;
      quo   <= frame_next;
      adv_q <= (frame_next != current_frame);
      done_q <= done_next;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? COLS_W'(trial - {1'b0, cols}) : trial[COLS_W-1:0];
      quo <= {quo[FRAME_BITS-2:0], trial_ge};
    end
  end

  // rem is the column, quo the row
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_index <= INDEX_W'(current_frame);
      src_x       <= XY_W'(rem) * XY_W'(cfg.cell_width);
      src_y       <= XY_W'(quo) * XY_W'(cfg.cell_height);
      advanced    <= adv_q;
      cycle_done  <= done_q;
    end
  end

  a_restart_range: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && (mode == MODE_RESTART) |=>
      moving_forward && (time_accumulator == '0) && (current_frame == working_start))
    else $error("restart left the range unloaded");

  a_done_no_pingpong: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && done_next |-> !pingpong && (frame_next == working_start))
    else $error("wrap flagged outside forward or reverse play");

  a_turn_flips: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && (mode == MODE_TICK) && fire && overrun && pingpong |=>
      (moving_forward != $past(moving_forward)) && (current_frame == working_start))
    else $error("ping-pong turn did not swap direction");

endmodule

>>> rtl/sprite_frame_sequencer.sv
// Sprite frame sequencer: frame stepping from elapsed time, sheet row/column split.
// Holds the configuration registers; uses sfs_pkg, sfs_ifs, sfs_ctrl and sfs_dpath.
//
// Each tick item adds its elapsed microseconds to a saturating 17-bit accumulator
// and takes at most one frame step once the frame period is exceeded; a restart
// item reloads the range and returns to the first frame. Every item yields one
// result. An item passes through these steps in order: its acceptance updates the
// animation state, the bit-serial restoring divider then splits the index into row
// and column, and the last step scales by the cell size and loads the output
// register. The next item is taken while the previous result waits in the output
// register; a result still held back when the following item reaches the scaling
// step stalls that item there.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sfs_tick_if.sink             tick,
  sfs_frame_if.source          frame
);

  cfg_t cfg;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period  <= RST_FRAME_PERIOD;
      cfg.step_size     <= RST_STEP_SIZE;
      cfg.first_frame   <= RST_FIRST_FRAME;
      cfg.last_frame    <= RST_LAST_FRAME;
      cfg.sheet_columns <= RST_SHEET_COLUMNS;
      cfg.cell_width    <= RST_CELL_WIDTH;
      cfg.cell_height   <= RST_CELL_HEIGHT;
      cfg.play_mode     <= RST_PLAY_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_PERIOD:  cfg.frame_period  <= cfg_data[PERIOD_W-1:0];
        REG_STEP_SIZE:     cfg.step_size     <= cfg_data[STEP_W-1:0];
        REG_FIRST_FRAME:   cfg.first_frame   <= cfg_data[RANGE_W-1:0];
        REG_LAST_FRAME:    cfg.last_frame    <= cfg_data[RANGE_W-1:0];
        REG_SHEET_COLUMNS: cfg.sheet_columns <= cfg_data[COLS_W-1:0];
        REG_CELL_WIDTH:    cfg.cell_width    <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT:   cfg.cell_height   <= cfg_data[CELL_W-1:0];
        REG_PLAY_MODE:     cfg.play_mode     <= cfg_data[PLAY_W-1:0];
        default: ;
      endcase
    end
  end

  sfs_ctrl #(
    .FRAME_BITS(FRAME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .cmd       (cmd)
  );

  sfs_dpath #(
    .FRAME_BITS(FRAME_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .mode        (tick.mode),
    .elapsed     (tick.elapsed),
    .frame_index (frame.frame_index),
    .src_x       (frame.src_x),
    .src_y       (frame.src_y),
    .advanced    (frame.advanced),
    .cycle_done  (frame.cycle_done)
  );

endmodule
